### rtl/core/pmct_pkg.sv
`timescale 1ns / 1ps

package pmct_pkg;

  // cursor coordinate width
  localparam int unsigned COORD_BITS = 10;
  localparam int unsigned CfgIdxBits = 2;
  localparam int unsigned DeltaExtBits = COORD_BITS + 2;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic signed [DeltaExtBits-1:0] coord_ext_t;

  typedef enum logic [CfgIdxBits-1:0] {
    CFG_X_LIMIT  = 2'd0,
    CFG_Y_LIMIT  = 2'd1,
    CFG_EDGE_LOW = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    BYTE_HEADER = 2'd0,
    BYTE_X      = 2'd1,
    BYTE_Y      = 2'd2
  } byte_pos_e;

  localparam coord_t XLimitRst  = COORD_BITS'(1014);
  localparam coord_t YLimitRst  = COORD_BITS'(758);
  localparam coord_t EdgeLowRst = COORD_BITS'(2);

  localparam logic [7:0] HdrXOvf    = 8'h80;
  localparam logic [7:0] HdrYOvf    = 8'h40;
  localparam logic [7:0] HdrBtnLeft = 8'h01;
  localparam logic [7:0] HdrBtnRight = 8'h02;
  localparam logic [7:0] HdrBtnMid  = 8'h04;

endpackage

### rtl/core/pmct_if.sv
`timescale 1ns / 1ps

interface pmct_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface pmct_pkt_if;
  logic                           valid;
  logic                           ready;
  logic [pmct_pkg::COORD_BITS-1:0] cursor_x;
  logic [pmct_pkg::COORD_BITS-1:0] cursor_y;
  logic                           left_button;
  logic                           right_button;
  logic                           middle_button;

  modport source (output valid, output cursor_x, output cursor_y, output left_button,
                  output right_button, output middle_button, input ready);
  modport sink   (input valid, input cursor_x, input cursor_y, input left_button,
                  input right_button, input middle_button, output ready);
endinterface

interface pmct_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [pmct_pkg::CfgIdxBits-1:0] reg_index;
  logic [pmct_pkg::COORD_BITS-1:0] wdata;

  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

### rtl/core/ps2_mouse_packet_cursor_tracker.sv
`timescale 1ns / 1ps

// Gathers mouse link bytes into three-byte packets (header, x delta, y delta) and
// keeps a cursor clamped to [edge_low, x_limit] and [edge_low, y_limit]; y grows
// downward, so the y delta is subtracted. A packet whose header has an overflow
// bit set is dropped without a result. One byte is taken per cycle unless a third
// byte is held; the third byte of a packet, as it leaves the input register, puts
// its result in the output register. The input register keeps filling while a
// result waits; it only holds a third byte until the output register is free.
// Configuration writes are taken at any time and must only happen while idle.
module ps2_mouse_packet_cursor_tracker (
  input  logic       clk_i,
  input  logic       rst_ni,
  pmct_cfg_if.sink   cfg_i,
  pmct_rx_if.sink    rx_i,
  pmct_pkt_if.source pkt_o
);
  import pmct_pkg::*;

  coord_t x_limit_q, y_limit_q, edge_low_q;

  logic       in_valid_q;
  logic [7:0] in_byte_q;

  byte_pos_e  pos_q, pos_d;
  logic [7:0] header_q, header_d;
  logic [7:0] x_delta_q, x_delta_d;
  coord_t     pos_x_q, pos_x_d;
  coord_t     pos_y_q, pos_y_d;
  logic [2:0] buttons_q, buttons_d;
  logic       out_valid_q, out_valid_d;

  logic in_fire, adv, is_last, ovf, emit;

  function automatic coord_t clamp_coord(coord_ext_t v, coord_t hi, coord_t lo);
    coord_ext_t r;
    r = v;
    if (r > $signed({2'b00, hi})) r = $signed({2'b00, hi});
    if (r < $signed({2'b00, lo})) r = $signed({2'b00, lo});
    return r[COORD_BITS-1:0];
  endfunction

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_limit_q  <= XLimitRst;
      y_limit_q  <= YLimitRst;
      edge_low_q <= EdgeLowRst;
    end else if (cfg_i.valid) begin
      case (cfg_i.reg_index)
        CFG_X_LIMIT:  x_limit_q  <= cfg_i.wdata;
        CFG_Y_LIMIT:  y_limit_q  <= cfg_i.wdata;
        CFG_EDGE_LOW: edge_low_q <= cfg_i.wdata;
        default: ;
      endcase
    end
  end

  assign is_last = (pos_q == BYTE_Y);
  assign ovf     = |(header_q & (HdrXOvf | HdrYOvf));
  assign emit    = in_valid_q && is_last && !ovf;
  // a result byte waits only while the previous result is still unread
  assign adv     = in_valid_q && !(emit && out_valid_q && !pkt_o.ready);
  assign rx_i.ready = !in_valid_q || adv;
  assign in_fire = rx_i.valid && rx_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (rx_i.ready) begin
      in_valid_q <= rx_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_byte_q <= rx_i.rx_byte;
    end
  end

  // byte position sequence
  always_comb begin
    pos_d = pos_q;
    if (adv) begin
      case (pos_q)
        BYTE_HEADER: pos_d = BYTE_X;
        BYTE_X:      pos_d = BYTE_Y;
        BYTE_Y:      pos_d = BYTE_HEADER;
        default:     pos_d = BYTE_HEADER;
      endcase
    end
  end

  always_comb begin
    header_d    = header_q;
    x_delta_d   = x_delta_q;
    pos_x_d     = pos_x_q;
    pos_y_d     = pos_y_q;
    buttons_d   = buttons_q;
    out_valid_d = out_valid_q && !pkt_o.ready;
    if (adv) begin
      case (pos_q)
        BYTE_HEADER: header_d = in_byte_q;
        BYTE_X:      x_delta_d = in_byte_q;
        BYTE_Y: begin
          if (!ovf) begin
            pos_x_d = clamp_coord($signed({2'b00, pos_x_q})
                                  + $signed({{(DeltaExtBits-8){x_delta_q[7]}}, x_delta_q}),
                                  x_limit_q, edge_low_q);
            pos_y_d = clamp_coord($signed({2'b00, pos_y_q})
                                  - $signed({{(DeltaExtBits-8){in_byte_q[7]}}, in_byte_q}),
                                  y_limit_q, edge_low_q);
            buttons_d = {|(header_q & HdrBtnMid), |(header_q & HdrBtnRight),
                         |(header_q & HdrBtnLeft)};
            out_valid_d = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= BYTE_HEADER;
      header_q    <= '0;
      x_delta_q   <= '0;
      pos_x_q     <= '0;
      pos_y_q     <= '0;
      buttons_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      header_q    <= header_d;
      x_delta_q   <= x_delta_d;
      pos_x_q     <= pos_x_d;
      pos_y_q     <= pos_y_d;
      buttons_q   <= buttons_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign pkt_o.valid         = out_valid_q;
  assign pkt_o.cursor_x      = pos_x_q;
  assign pkt_o.cursor_y      = pos_y_q;
  assign pkt_o.left_button   = buttons_q[0];
  assign pkt_o.right_button  = buttons_q[1];
  assign pkt_o.middle_button = buttons_q[2];

  a_x_in_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && edge_low_q <= x_limit_q) |->
      (pos_x_q <= x_limit_q && pos_x_q >= edge_low_q))
    else $error("cursor x outside limits");

  a_emit_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && emit) |=> out_valid_q)
    else $error("packet result not presented");

  a_wrap_to_header: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && is_last) |=> pos_q == BYTE_HEADER)
    else $error("byte position did not wrap after third byte");

  a_cursor_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> ($stable(pos_x_q) && $stable(pos_y_q) && $stable(buttons_q)))
    else $error("cursor changed without a byte");

endmodule
